>>> rtl/ucl_pkg.sv
package ucl_pkg;

    // command codes carried in the input word
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // status codes returned with every result word
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE
    } state_t;

    localparam int ID_W    = 32;
    localparam int COUNT_W = 7;

    // input word
    typedef struct packed {
        logic [1:0]      cmd;
        logic [ID_W-1:0] id;
    } req_t;

    // result word
    typedef struct packed {
        logic [2:0]         status;
        logic [COUNT_W-1:0] count;
    } rsp_t;

endpackage

>>> rtl/unique_id_list_with_compaction_top.sv
// Ordered list of unique 32-bit ids with compaction on remove.
// Input channel: a command word (req.cmd, req.id) is taken at a rising edge
// where start is high and busy is low. busy stays high while the command runs.
// Output channel: one result word (rsp.status, rsp.count) per command, shown
// for exactly one cycle while done is high; the receiver cannot stall it.
// Sequencing per command:
//   pop, nop, or push or remove on an empty list : answered from idle
//   push   : read and compare each entry in turn, stop at a match (dup),
//            then append the id after the last entry unless the list is full
//   remove : compare until a match, then move each later entry down by one
// Each entry visited passes once through the single comparator or the
// single move path, with one read of the entry memory per entry. A new
// command may be started in the cycle done is high.
// Reset clears the live count and the sequencer; the entry memory keeps
// whatever it held, and only positions below the count are ever read.
module unique_id_list_with_compaction_top #(
    parameter int DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  ucl_pkg::req_t req,
    output logic         done,
    output ucl_pkg::rsp_t rsp
);
    import ucl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // entry memory
    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;
    logic            rd_en;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [ID_W-1:0] mem_wdata;

    state_t          state_reg, state_next;
    logic [CW-1:0]   live_count_reg, live_count_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   k_plus;
    logic [1:0]      cmd_reg, cmd_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            done_reg, done_next;
    status_t         status_reg, status_next;
    logic            hit;
    logic            last;
    logic            full;
    logic [CW+COUNT_W-1:0] count_ext;

    // shared compare and position tests
    assign k_plus = k_reg + CW'(1);
    assign hit    = (rd_data_reg == id_reg);
    assign last   = (k_plus == live_count_reg);
    assign full   = (live_count_reg == CW'(DEPTH));

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[k_reg[AW-1:0]];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((cmd_t'(req.cmd) == CMD_PUSH || cmd_t'(req.cmd) == CMD_REMOVE)
                        && live_count_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit)
                begin
                    if (cmd_t'(cmd_reg) == CMD_PUSH || last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (last)
                begin
                    if (cmd_t'(cmd_reg) == CMD_PUSH && !full)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = last ? S_IDLE : S_SHIFT_RD;
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        live_count_next = live_count_reg;
        k_next          = k_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        rd_en           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = live_count_reg[AW-1:0];
        mem_wdata       = id_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = req.cmd;
                    id_next  = req.id;
                    k_next   = '0;
                    unique case (cmd_t'(req.cmd))
                        CMD_PUSH:
                        begin
                            // empty list: append at once
                            if (live_count_reg == '0)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = req.id;
                                live_count_next = CW'(1);
                                done_next       = 1'b1;
                                status_next     = ST_OK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (live_count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOTFOUND;
                            end
                        end
                        CMD_POP:
                        begin
                            done_next = 1'b1;
                            if (live_count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                live_count_next = live_count_reg - CW'(1);
                                status_next     = ST_OK;
                            end
                        end
                        CMD_NOP:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_en = 1'b1;
            end
            S_CMP:
            begin
                if (hit)
                begin
                    if (cmd_t'(cmd_reg) == CMD_PUSH)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_DUP;
                    end
                    else if (last)
                    begin
                        // removed the tail entry, nothing to move
                        live_count_next = live_count_reg - CW'(1);
                        done_next       = 1'b1;
                        status_next     = ST_OK;
                    end
                    else
                    begin
                        k_next = k_plus;
                    end
                end
                else if (last)
                begin
                    if (cmd_t'(cmd_reg) == CMD_PUSH)
                    begin
                        if (full)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOTFOUND;
                    end
                end
                else
                begin
                    k_next = k_plus;
                end
            end
            S_SHIFT_RD:
            begin
                rd_en = 1'b1;
            end
            S_SHIFT_WR:
            begin
                // move entry k down to k-1
                mem_we    = 1'b1;
                mem_waddr = k_reg[AW-1:0] - AW'(1);
                mem_wdata = rd_data_reg;
                if (last)
                begin
                    live_count_next = live_count_reg - CW'(1);
                    done_next       = 1'b1;
                    status_next     = ST_OK;
                end
                else
                begin
                    k_next = k_plus;
                end
            end
            S_WRITE:
            begin
                mem_we          = 1'b1;
                live_count_next = live_count_reg + CW'(1);
                done_next       = 1'b1;
                status_next     = ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        status_reg <= status_next;
    end

    // outputs
    assign count_ext  = {{COUNT_W{1'b0}}, live_count_reg};
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = count_ext[COUNT_W-1:0];

`ifndef SYNTH
    // a result word only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    // the live count never exceeds the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= CW'(DEPTH))
        else $error("live count beyond depth");

    // pop on an empty list answers empty next cycle with count unchanged
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd_t'(req.cmd) == CMD_POP && live_count_reg == '0)
        |=> (done && rsp.status == ST_EMPTY && live_count_reg == '0))
        else $error("pop on empty list mishandled");

    // a successful push grows the list by exactly one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_OK && cmd_t'(cmd_reg) == CMD_PUSH
         && $past(state_reg) != S_IDLE)
        |-> (live_count_reg == $past(live_count_reg) + CW'(1)))
        else $error("push did not grow list by one");
`endif

endmodule
